// ===== src/module_config_address_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Module configuration address decoder: assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MODULE_CONFIG_ADDRESS_DECODER_ASSERT_SVH
`define MODULE_CONFIG_ADDRESS_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MCAD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcad check failed");

// next-cycle implication, checked outside reset
`define MCAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcad check failed");

`endif

// ===== src/mcad_pkg.sv =====
// ----------------------------------------------------------------------------
// mcad_pkg
// Types, codes and helper functions shared by the decoder and its cells.
// ----------------------------------------------------------------------------
package mcad_pkg;

    // field widths
    localparam int CMD_W      = 3;
    localparam int BUS_W      = 20;
    localparam int IDX_W      = 3;
    localparam int PH_W       = 2;
    localparam int MASK_W     = 6;
    localparam int LG_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CODE_W     = 8;
    localparam int SIZE_W     = 33;

    // commands
    localparam logic [CMD_W-1:0] CMD_DECODE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CONFIG      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNCONF_ADDR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNCONF_ALL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY_ID    = 3'd4;

    // configuration phases
    localparam logic [PH_W-1:0] PH_UNCONF = 2'd0;
    localparam logic [PH_W-1:0] PH_SIZED  = 2'd1;
    localparam logic [PH_W-1:0] PH_DONE   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_LG       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAM_LG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARD1_LG     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CARD2_LG     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CARD3_LG     = 3'd6;

    // module slots
    localparam int SLOT_ROM   = 0;
    localparam int SLOT_IO    = 1;
    localparam int SLOT_RAM   = 2;
    localparam int SLOT_CARD1 = 3;
    localparam int SLOT_CARD2 = 4;
    localparam int SLOT_CARD3 = 5;

    // reset values
    localparam logic [MASK_W-1:0] RESET_MASK  = 6'd63;
    localparam logic [LG_W-1:0] RESET_ROM_LG  = 5'd19;
    localparam logic [LG_W-1:0] RESET_RAM_LG  = 5'd16;
    localparam logic [LG_W-1:0] RESET_CARD_LG = 5'd18;
    localparam int IO_BASE = 'h100;

    // card id codes, unconfigured and size configured
    localparam logic [CODE_W-1:0] ID_UNCONF_CODE [3] = '{8'h05, 8'h07, 8'h01};
    localparam logic [CODE_W-1:0] ID_SIZED_CODE  [3] = '{8'hf6, 8'hf8, 8'hf2};

    // word handed from one cell to the next
    typedef struct packed {
        logic             taken;
        logic             dec_hit;
        logic             dec_rom;
        logic [IDX_W-1:0] dec_index;
        logic [BUS_W-1:0] dec_offset;
        logic             id_fault;
        logic [BUS_W-1:0] id_value;
    } chain_t;

    // id code of a card slot
    function automatic logic [CODE_W-1:0] id_code(input int slot, input bit sized);
        logic [CODE_W-1:0] code;
        code = '0;
        if (slot >= SLOT_CARD1 && slot <= SLOT_CARD3) begin
            code = sized ? ID_SIZED_CODE[slot-SLOT_CARD1] : ID_UNCONF_CODE[slot-SLOT_CARD1];
        end
        return code;
    endfunction

    // 2^lg with lg clamped to the address width
    function automatic logic [SIZE_W-1:0] pow_size(input logic [LG_W-1:0] lg, input int aw);
        int sh;
        sh = (int'(lg) > aw) ? aw : int'(lg);
        return SIZE_W'(1) << sh;
    endfunction

    // real size of a slot
    function automatic logic [SIZE_W-1:0] module_size(
        input int slot, input int aw, input int io_size,
        input logic [LG_W-1:0] rom_lg, input logic [LG_W-1:0] ram_lg,
        input logic [LG_W-1:0] c1_lg, input logic [LG_W-1:0] c2_lg,
        input logic [LG_W-1:0] c3_lg);
        logic [SIZE_W-1:0] size;
        case (slot)
            SLOT_ROM:   size = pow_size(rom_lg, aw);
            SLOT_IO:    size = SIZE_W'(io_size);
            SLOT_RAM:   size = pow_size(ram_lg, aw);
            SLOT_CARD1: size = pow_size(c1_lg, aw);
            SLOT_CARD2: size = pow_size(c2_lg, aw);
            SLOT_CARD3: size = pow_size(c3_lg, aw);
            default:    size = SIZE_W'(1);
        endcase
        return size;
    endfunction

endpackage

// ===== src/mcad_cell.sv =====
// ----------------------------------------------------------------------------
// mcad_cell
// One memory module slot: phase, base and window, plus its link in the
// decode and configuration priority chain.
// ----------------------------------------------------------------------------
module mcad_cell #(
    parameter int CELL_INDEX   = 0,
    parameter int ADDRESS_BITS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [mcad_pkg::CMD_W-1:0]    command,
    input  logic [ADDRESS_BITS-1:0]       bus_addr,
    input  logic                          present,
    input  logic                          active,
    input  logic [ADDRESS_BITS:0]         natural_size,
    input  logic [ADDRESS_BITS:0]         reset_size,
    input  mcad_pkg::chain_t              chain_in,
    output mcad_pkg::chain_t              chain_out,
    output logic [mcad_pkg::PH_W-1:0]     phase
);
    import mcad_pkg::*;

    localparam bit IS_ROM    = (CELL_INDEX == SLOT_ROM);
    localparam bit IS_IO     = (CELL_INDEX == SLOT_IO);
    localparam bit LOW_FAULT = (CELL_INDEX <= SLOT_RAM);
    localparam logic [PH_W-1:0] RESET_PHASE = (IS_ROM || IS_IO) ? PH_DONE : PH_UNCONF;
    localparam logic [ADDRESS_BITS-1:0] RESET_BASE = IS_IO ? ADDRESS_BITS'(IO_BASE) : '0;

    logic [PH_W-1:0]         phase_reg, phase_next;
    logic [ADDRESS_BITS-1:0] base_reg, base_next;
    logic [ADDRESS_BITS:0]   window_reg, window_next;

    logic                    covers, win_here, pending, target;
    logic [ADDRESS_BITS-1:0] diff, size_mask, offset, neg_bus;
    logic [ADDRESS_BITS:0]   window_end, span, unconf_id, sized_id;

    // window match
    assign window_end = {1'b0, base_reg} + window_reg;
    assign covers     = active && (phase_reg == PH_DONE) && (bus_addr >= base_reg)
                        && ({1'b0, bus_addr} < window_end);
    assign win_here   = covers && (!chain_in.dec_hit || chain_in.dec_rom);

    // offset modulo the real size, io window is never wider than its size
    assign diff      = bus_addr - base_reg;
    assign size_mask = natural_size[ADDRESS_BITS-1:0] - ADDRESS_BITS'(1);
    assign offset    = IS_IO ? diff : (diff & size_mask);

    // first present module not yet configured
    assign pending = present && (phase_reg != PH_DONE);
    assign target  = pending && !chain_in.taken;

    // card id values
    assign span      = {1'b1, {ADDRESS_BITS{1'b0}}};
    assign unconf_id = span - natural_size + (ADDRESS_BITS+1)'(id_code(CELL_INDEX, 1'b0));
    assign sized_id  = {1'b0, base_reg} + (ADDRESS_BITS+1)'(id_code(CELL_INDEX, 1'b1));
    assign neg_bus   = '0 - bus_addr;

    // chain word to the next cell
    always_comb begin
        chain_out       = chain_in;
        chain_out.taken = chain_in.taken || pending;
        if (win_here) begin
            chain_out.dec_hit    = 1'b1;
            chain_out.dec_rom    = IS_ROM;
            chain_out.dec_index  = IDX_W'(CELL_INDEX);
            chain_out.dec_offset = BUS_W'(offset);
        end
        if (target) begin
            chain_out.id_fault = LOW_FAULT;
            if (LOW_FAULT) begin
                chain_out.id_value = '0;
            end else if (phase_reg == PH_UNCONF) begin
                chain_out.id_value = BUS_W'(unconf_id);
            end else begin
                chain_out.id_value = BUS_W'(sized_id);
            end
        end
    end

    // state update
    always_comb begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        window_next = window_reg;
        if (step) begin
            case (command)
                CMD_CONFIG: begin
                    if (target) begin
                        if (IS_IO) begin
                            window_next = natural_size;
                            base_next   = bus_addr;
                            phase_next  = PH_DONE;
                        end else if (phase_reg == PH_UNCONF) begin
                            window_next = {1'b0, neg_bus};
                            phase_next  = PH_SIZED;
                        end else begin
                            base_next  = bus_addr;
                            phase_next = PH_DONE;
                        end
                    end
                end
                CMD_UNCONF_ADDR: begin
                    if (win_here && present && !IS_ROM) begin
                        base_next   = '0;
                        window_next = natural_size;
                        phase_next  = PH_UNCONF;
                    end
                end
                CMD_UNCONF_ALL: begin
                    if (present && !IS_ROM) begin
                        base_next   = '0;
                        window_next = natural_size;
                        phase_next  = PH_UNCONF;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= RESET_PHASE;
            base_reg   <= RESET_BASE;
            window_reg <= reset_size;
        end else begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            window_reg <= window_next;
        end
    end

    assign phase = phase_reg;

endmodule

// ===== src/module_config_address_decoder.sv =====
// ----------------------------------------------------------------------------
// module_config_address_decoder
// Daisy-chain configuration and address decode for the memory modules of a
// nibble bus.
// ----------------------------------------------------------------------------
// Takes one command word per clock and returns one result word for each, in the
// cycle after the command is accepted; the input is stalled only while a
// finished result waits in the output register. Each module slot is a cell in
// a row, and the decode priority, the configuration target and the id answer
// ripple through that row inside the cycle, so the row length sets the timing
// path. Configuration writes are always accepted and must arrive while the
// block is idle.
`include "module_config_address_decoder_assert.svh"

module module_config_address_decoder #(
    parameter int MODULE_COUNT   = 6,
    parameter int IO_WINDOW_SIZE = 64,
    parameter int ADDRESS_BITS   = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command, bus_value
    input  logic [23:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hit, module_index, module_offset, id_value, id_fault
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcad_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mcad_pkg::*;

    logic [MASK_W-1:0] present_mask_reg, active_mask_reg;
    logic [LG_W-1:0]   rom_lg_reg, ram_lg_reg, card1_lg_reg, card2_lg_reg, card3_lg_reg;

    logic                    s_accept;
    logic [CMD_W-1:0]        command;
    logic [BUS_W-1:0]        bus_value;
    logic [ADDRESS_BITS-1:0] bus_addr;

    chain_t            chain [MODULE_COUNT+1];
    logic [PH_W-1:0]   phase_vec [MODULE_COUNT];

    logic              m_valid_reg;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [BUS_W-1:0]  offset_reg, offset_next;
    logic [BUS_W-1:0]  id_value_reg, id_value_next;
    logic              id_fault_reg, id_fault_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_mask_reg <= RESET_MASK;
            active_mask_reg  <= RESET_MASK;
            rom_lg_reg       <= RESET_ROM_LG;
            ram_lg_reg       <= RESET_RAM_LG;
            card1_lg_reg     <= RESET_CARD_LG;
            card2_lg_reg     <= RESET_CARD_LG;
            card3_lg_reg     <= RESET_CARD_LG;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PRESENT_MASK: present_mask_reg <= cfg_data;
                REG_ACTIVE_MASK:  active_mask_reg  <= cfg_data;
                REG_ROM_LG:       rom_lg_reg       <= cfg_data[LG_W-1:0];
                REG_RAM_LG:       ram_lg_reg       <= cfg_data[LG_W-1:0];
                REG_CARD1_LG:     card1_lg_reg     <= cfg_data[LG_W-1:0];
                REG_CARD2_LG:     card2_lg_reg     <= cfg_data[LG_W-1:0];
                REG_CARD3_LG:     card3_lg_reg     <= cfg_data[LG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input word
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign command   = s_tdata[CMD_W-1:0];
    assign bus_value = s_tdata[CMD_W+BUS_W-1:CMD_W];
    assign bus_addr  = ADDRESS_BITS'(bus_value);

    // row of module cells
    assign chain[0] = '0;

    for (genvar g = 0; g < MODULE_COUNT; g++) begin : g_cell
        logic                  present, active;
        logic [ADDRESS_BITS:0] natural_size, reset_size;

        if (g < MASK_W) begin : g_mask
            assign present = present_mask_reg[g];
            assign active  = active_mask_reg[g];
        end else begin : g_nomask
            assign present = 1'b0;
            assign active  = 1'b0;
        end

        assign natural_size = (ADDRESS_BITS+1)'(module_size(g, ADDRESS_BITS, IO_WINDOW_SIZE,
                               rom_lg_reg, ram_lg_reg, card1_lg_reg, card2_lg_reg,
                               card3_lg_reg));
        assign reset_size   = (ADDRESS_BITS+1)'(module_size(g, ADDRESS_BITS, IO_WINDOW_SIZE,
                               RESET_ROM_LG, RESET_RAM_LG, RESET_CARD_LG, RESET_CARD_LG,
                               RESET_CARD_LG));

        mcad_cell #(
            .CELL_INDEX   (g),
            .ADDRESS_BITS (ADDRESS_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .step         (s_accept),
            .command      (command),
            .bus_addr     (bus_addr),
            .present      (present),
            .active       (active),
            .natural_size (natural_size),
            .reset_size   (reset_size),
            .chain_in     (chain[g]),
            .chain_out    (chain[g+1]),
            .phase        (phase_vec[g])
        );
    end

    // result word from the end of the row
    always_comb begin
        hit_next      = 1'b0;
        index_next    = '0;
        offset_next   = '0;
        id_value_next = '0;
        id_fault_next = 1'b0;
        case (command)
            CMD_DECODE: begin
                hit_next    = chain[MODULE_COUNT].dec_hit;
                index_next  = chain[MODULE_COUNT].dec_index;
                offset_next = chain[MODULE_COUNT].dec_offset;
            end
            CMD_QUERY_ID: begin
                id_value_next = chain[MODULE_COUNT].id_value;
                id_fault_next = chain[MODULE_COUNT].id_fault;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hit_reg      <= hit_next;
            index_reg    <= index_next;
            offset_reg   <= offset_next;
            id_value_reg <= id_value_next;
            id_fault_reg <= id_fault_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, id_fault_reg, id_value_reg, offset_reg, index_reg, hit_reg};

    // checks
    `MCAD_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_accept, m_valid_reg)
    `MCAD_ASSERT_NOW(a_rom_stays_done, aclk, aresetn, 1'b1, phase_vec[SLOT_ROM] == PH_DONE)
    `MCAD_ASSERT_NOW(a_io_never_sized, aclk, aresetn, 1'b1, phase_vec[SLOT_IO] != PH_SIZED)
    `MCAD_ASSERT_NOW(a_hit_no_id, aclk, aresetn, m_valid_reg && hit_reg, !id_fault_reg && (id_value_reg == '0))

endmodule
